[sv/ajrq_pkg.sv]
package ajrq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int SEQ_W      = 16;
    localparam int HANDLE_W   = 32;
    localparam int THRESH_W   = 5;
    localparam int OCC_W      = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [THRESH_W-1:0] PREFILL_RESET = THRESH_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PREFILL_THRESHOLD = 1'b0,
        REG_RECEIVE_PAUSED    = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_FETCH = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_SORT_LEFT,
        CELL_SORT_RIGHT
    } cell_mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_SORT
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        cell_mode_t mode;
        entry_t     load_word;
    } cell_ctrl_t;

endpackage

[sv/ajrq_cell.sv]
// One queue slot. Takes its right neighbor on a shift, the new word on a load,
// and does its half of a compare-swap during a sort pass.
module ajrq_cell (
    input  logic               clk,
    input  ajrq_pkg::cell_ctrl_t ctrl,
    input  ajrq_pkg::entry_t   left_word,
    input  ajrq_pkg::entry_t   right_word,
    output ajrq_pkg::entry_t   word
);

    ajrq_pkg::entry_t data_reg;
    ajrq_pkg::entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            ajrq_pkg::CELL_SHIFT:
                data_next = right_word;
            ajrq_pkg::CELL_LOAD:
                data_next = ctrl.load_word;
            // strict compare keeps equal sequences in arrival order
            ajrq_pkg::CELL_SORT_LEFT:
                if (right_word.seq < data_reg.seq)
                begin
                    data_next = right_word;
                end
            ajrq_pkg::CELL_SORT_RIGHT:
                if (data_reg.seq < left_word.seq)
                begin
                    data_next = left_word;
                end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;

endmodule

[sv/audio_jitter_reorder_queue.sv]
// Channel   | Direction | Signals                                         | Handshake
// ----------+-----------+-------------------------------------------------+---------------------
// command   | in        | action, frame_sequence, frame_handle            | start & !busy
// result    | out       | fetched_valid/handle/sequence, dropped_valid/   | done, one-cycle strobe
//           |           | handle, occupancy                               |
// config    | in        | cfg_index, cfg_data                             | cfg_write
//
// A fetch, a paused push or an in-order push is taken with busy staying low;
// its word is on the result ports with done in the next cycle.
// A push below the previous sequence runs QUEUE_DEPTH odd-even transposition
// passes through the cell row, one per cycle, with busy high; its word shows
// with done after the last pass. Reset is asynchronous, active low;
// slots are not cleared. The receiver cannot stall: done lasts one cycle.
module audio_jitter_reorder_queue #(
    parameter int QUEUE_DEPTH = ajrq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [ajrq_pkg::SEQ_W-1:0]        frame_sequence,
    input  logic [ajrq_pkg::HANDLE_W-1:0]     frame_handle,
    output logic                              done,
    output logic                              fetched_valid,
    output logic [ajrq_pkg::HANDLE_W-1:0]     fetched_handle,
    output logic [ajrq_pkg::SEQ_W-1:0]        fetched_sequence,
    output logic                              dropped_valid,
    output logic [ajrq_pkg::HANDLE_W-1:0]     dropped_handle,
    output logic [ajrq_pkg::OCC_W-1:0]        occupancy,
    input  logic                              cfg_write,
    input  logic [ajrq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ajrq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // count holds 0..QUEUE_DEPTH, pass counter 0..QUEUE_DEPTH-1
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CMP_W = (CW > ajrq_pkg::THRESH_W) ? CW : ajrq_pkg::THRESH_W;

    ajrq_pkg::state_t                     state_reg, state_next;
    logic [PW-1:0]                        pass_reg, pass_next;
    logic [CW-1:0]                        count_reg, count_next;
    logic [ajrq_pkg::SEQ_W-1:0]           prev_seq_reg, prev_seq_next;
    logic [ajrq_pkg::THRESH_W-1:0]        prefill_rem_reg, prefill_rem_next;
    logic                                 paused_reg, paused_next;
    logic                                 done_reg, done_next;
    logic                                 fv_reg, fv_next;
    logic                                 dv_reg, dv_next;
    logic [ajrq_pkg::HANDLE_W-1:0]        fh_reg, fh_next;
    logic [ajrq_pkg::SEQ_W-1:0]           fs_reg, fs_next;
    logic [ajrq_pkg::HANDLE_W-1:0]        dh_reg, dh_next;
    logic [ajrq_pkg::OCC_W-1:0]           occ_reg, occ_next;

    logic accept;
    logic do_push;
    logic do_fetch;
    logic full;
    logic need_sort;
    logic sort_step;
    logic last_pass;
    logic phase;

    ajrq_pkg::entry_t     new_word;
    ajrq_pkg::entry_t     cell_word [QUEUE_DEPTH];
    ajrq_pkg::cell_ctrl_t cell_ctrl [QUEUE_DEPTH];

    // ---------------------------------------------------------------
    // command decode
    // ---------------------------------------------------------------
    assign accept    = start && !busy;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign do_push   = accept && (action == ajrq_pkg::ACT_PUSH) && !paused_reg;
    // fetch only when more words are buffered than the prefill still asks for
    assign do_fetch  = accept && (action == ajrq_pkg::ACT_FETCH) && (count_reg != '0)
                       && (CMP_W'(count_reg) > CMP_W'(prefill_rem_reg));
    assign need_sort = do_push && (frame_sequence < prev_seq_reg);
    assign last_pass = (pass_reg == PW'(QUEUE_DEPTH - 1));
    assign phase     = pass_reg[0];

    assign new_word.seq    = frame_sequence;
    assign new_word.handle = frame_handle;

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ajrq_pkg::ST_IDLE:
                if (need_sort)
                begin
                    state_next = ajrq_pkg::ST_SORT;
                end
            ajrq_pkg::ST_SORT:
                if (last_pass)
                begin
                    state_next = ajrq_pkg::ST_IDLE;
                end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        busy      = 1'b0;
        sort_step = 1'b0;
        unique case (state_reg)
            ajrq_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                sort_step = 1'b0;
            end
            ajrq_pkg::ST_SORT:
            begin
                busy      = 1'b1;
                sort_step = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // cell row: per-slot control
    // ---------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[i].mode      = ajrq_pkg::CELL_HOLD;
            cell_ctrl[i].load_word = new_word;
            if (do_push)
            begin
                if (full)
                begin
                    // evict the front: everything moves down, new word at the back
                    cell_ctrl[i].mode = (i == QUEUE_DEPTH - 1) ? ajrq_pkg::CELL_LOAD
                                                                : ajrq_pkg::CELL_SHIFT;
                end
                else if (count_reg == CW'(i))
                begin
                    cell_ctrl[i].mode = ajrq_pkg::CELL_LOAD;
                end
            end
            else if (do_fetch)
            begin
                cell_ctrl[i].mode = ajrq_pkg::CELL_SHIFT;
            end
            else if (sort_step)
            begin
                // pairs (i, i+1) with i of the current parity, both slots in use
                if ((1'(i % 2) == phase) && (CW'(i + 1) < count_reg))
                begin
                    cell_ctrl[i].mode = ajrq_pkg::CELL_SORT_LEFT;
                end
                else if ((i >= 1) && (1'((i + 1) % 2) == phase) && (CW'(i) < count_reg))
                begin
                    cell_ctrl[i].mode = ajrq_pkg::CELL_SORT_RIGHT;
                end
            end
        end

        ajrq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .left_word  (cell_word[(i == 0) ? 0 : i - 1]),
            .right_word (cell_word[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .word       (cell_word[i])
        );
    end

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    always_comb
    begin
        pass_next        = sort_step ? pass_reg + PW'(1) : '0;
        count_next       = count_reg;
        prev_seq_next    = prev_seq_reg;
        prefill_rem_next = prefill_rem_reg;
        paused_next      = paused_reg;
        done_next        = (accept && !need_sort) || (sort_step && last_pass);

        if (do_push)
        begin
            prev_seq_next = frame_sequence;
            if (!full)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (do_fetch)
        begin
            count_next = count_reg - CW'(1);
            if (prefill_rem_reg != '0)
            begin
                prefill_rem_next = prefill_rem_reg - ajrq_pkg::THRESH_W'(1);
            end
        end

        // user writes only while idle, not enforced here; a threshold write reloads the prefill count
        if (cfg_write)
        begin
            unique case (ajrq_pkg::cfg_reg_t'(cfg_index))
                ajrq_pkg::REG_PREFILL_THRESHOLD:
                    prefill_rem_next = cfg_data[ajrq_pkg::THRESH_W-1:0];
                ajrq_pkg::REG_RECEIVE_PAUSED:
                    paused_next = cfg_data[0];
            endcase
        end
    end

    // result word, captured at accept and held through a sort
    always_comb
    begin
        fv_next  = fv_reg;
        fh_next  = fh_reg;
        fs_next  = fs_reg;
        dv_next  = dv_reg;
        dh_next  = dh_reg;
        occ_next = occ_reg;
        if (accept)
        begin
            fv_next  = do_fetch;
            fh_next  = do_fetch ? cell_word[0].handle : '0;
            fs_next  = do_fetch ? cell_word[0].seq : '0;
            dv_next  = do_push && full;
            dh_next  = (do_push && full) ? cell_word[0].handle : '0;
            occ_next = ajrq_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ajrq_pkg::ST_IDLE;
            pass_reg        <= '0;
            count_reg       <= '0;
            prev_seq_reg    <= '0;
            prefill_rem_reg <= ajrq_pkg::PREFILL_RESET;
            paused_reg      <= 1'b0;
            done_reg        <= 1'b0;
            fv_reg          <= 1'b0;
            dv_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pass_reg        <= pass_next;
            count_reg       <= count_next;
            prev_seq_reg    <= prev_seq_next;
            prefill_rem_reg <= prefill_rem_next;
            paused_reg      <= paused_next;
            done_reg        <= done_next;
            fv_reg          <= fv_next;
            dv_reg          <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fh_reg  <= fh_next;
        fs_reg  <= fs_next;
        dh_reg  <= dh_next;
        occ_reg <= occ_next;
    end

    assign done             = done_reg;
    assign fetched_valid    = fv_reg;
    assign fetched_handle   = fh_reg;
    assign fetched_sequence = fs_reg;
    assign dropped_valid    = dv_reg;
    assign dropped_handle   = dh_reg;
    assign occupancy        = occ_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result word shown while sort still running");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || busy))
        else $error("accepted word neither answered nor sorting");

    a_sort_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        sort_step |=> $stable(count_reg))
        else $error("queue count changed during a sort");

endmodule
